### rtl/core/ile_pkg.sv
// Shared types and constants for the indexed list engine.
`timescale 1ns / 1ps

package ile_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int WORD_W   = 32;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]         t_cnt;

    typedef enum logic [3:0] {
        MODE_PUSHBACK  = 4'd0,
        MODE_PUSHFRONT = 4'd1,
        MODE_INSERT    = 4'd2,
        MODE_POPFRONT  = 4'd3,
        MODE_POPBACK   = 4'd4,
        MODE_DELETE    = 4'd5,
        MODE_FRONT     = 4'd6,
        MODE_BACK      = 4'd7,
        MODE_CLEAR     = 4'd8,
        MODE_SIZE      = 4'd9,
        MODE_GET       = 4'd10,
        MODE_REPLACE   = 4'd11,
        MODE_EXISTS    = 4'd12,
        MODE_EQUAL     = 4'd13,
        MODE_SWAP      = 4'd14
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADIDX = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_WRITE,
        OP_SWAP
    } t_op;

    typedef enum logic [2:0] {
        SRC_HOLD,
        SRC_PREV,
        SRC_NEXT,
        SRC_VALUE,
        SRC_ALT
    } t_src;

    typedef struct packed {
        t_src  src;
        t_word alt;
    } t_cell_ctl;

    typedef struct packed {
        logic [3:0]  mode;
        t_word       value;
        logic [4:0]  index;
        logic [3:0]  second_index;
    } t_in_req;

    typedef struct packed {
        t_word       data;
        logic        flag;
        logic [4:0]  count;
        logic [1:0]  status;
    } t_out_rsp;

endpackage

### rtl/core/ile_cell.sv
// One list cell: holds a single element and takes data from its neighbors, the request value or a swap partner.
`timescale 1ns / 1ps

module ile_cell (
    input  logic              i_clk,
    input  ile_pkg::t_cell_ctl i_ctl,
    input  ile_pkg::t_word    i_prev,
    input  ile_pkg::t_word    i_next,
    input  ile_pkg::t_word    i_value,
    output ile_pkg::t_word    o_data,
    output logic              o_match
);
    import ile_pkg::*;

    t_word r_data;
    t_word n_data;

    always_comb begin
        case (i_ctl.src)
            SRC_PREV:  n_data = i_prev;
            SRC_NEXT:  n_data = i_next;
            SRC_VALUE: n_data = i_value;
            SRC_ALT:   n_data = i_ctl.alt;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_value);

endmodule

### rtl/core/indexed_list_engine_top.sv
// Top level of the indexed list engine: decode, cell chain and result register.
`timescale 1ns / 1ps
//
// Bounded ordered list of signed 32-bit values, 16 entries, front at index 0.
// Request channel: i_in_valid / o_in_ready with payload i_req (mode, value,
// index, second_index). Result channel: o_out_valid / i_out_ready with
// payload o_rsp (data, flag, count, status). Every request gives one result.
// Latency: the result is valid in the cycle after the request is taken.
// Throughput: one request per cycle unless the result register stalls; every
// mode, shifts and searches included, is applied at the edge taking the
// request, as each cell loads from its neighbor, the request value or a swap
// partner in parallel, and the membership test is a compare in every cell.
// Reset: synchronous, active low; the list becomes empty and no result is
// pending. Entry contents are not cleared.
// Stall: the result register holds while i_out_ready is low; a new request is
// taken only when the result register is empty or being drained that cycle.
//
module indexed_list_engine_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ile_pkg::t_in_req  i_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ile_pkg::t_out_rsp o_rsp
);
    import ile_pkg::*;

    localparam t_cnt CAP_CNT = CNT_W'(CAPACITY);

    t_cnt      r_count;
    t_cnt      n_count;
    logic      r_out_valid;
    t_out_rsp  r_rsp;
    t_out_rsp  n_rsp;

    logic      in_acc;
    logic      full;
    t_op       op;
    t_op       op_act;
    t_cnt      pos;
    t_cnt      pos2;
    logic [IDX_W-1:0] rd_addr;
    t_word     rd_a;
    t_word     rd_b;
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] cell_match;
    t_word     cell_data [CAPACITY];
    t_cell_ctl cell_ctl  [CAPACITY];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign full       = (r_count >= CAP_CNT);
    assign pos2       = CNT_W'(i_req.second_index);
    assign op_act     = in_acc ? op : OP_NONE;

    always_comb begin
        case (i_req.mode)
            MODE_FRONT: rd_addr = '0;
            MODE_BACK:  rd_addr = IDX_W'(r_count - 1'b1);
            default:    rd_addr = i_req.index[IDX_W-1:0];
        endcase
    end

    assign rd_a = cell_data[rd_addr];
    assign rd_b = cell_data[i_req.second_index[IDX_W-1:0]];

    always_comb begin
        n_rsp.data   = '0;
        n_rsp.flag   = 1'b0;
        n_rsp.status = ST_OK;
        n_count      = r_count;
        op           = OP_NONE;
        pos          = i_req.index;
        case (i_req.mode)
            MODE_PUSHBACK, MODE_PUSHFRONT: begin
                if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    op      = OP_INSERT;
                    pos     = (i_req.mode == MODE_PUSHBACK) ? r_count : '0;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_INSERT: begin
                if (i_req.index > r_count) begin
                    n_rsp.status = ST_BADIDX;
                end else if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    op      = OP_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_POPFRONT, MODE_POPBACK: begin
                if (r_count == '0) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    op      = OP_REMOVE;
                    pos     = (i_req.mode == MODE_POPBACK) ? r_count - 1'b1 : '0;
                    n_count = r_count - 1'b1;
                end
            end
            MODE_DELETE: begin
                if (r_count == '0) begin
                    n_rsp.status = ST_EMPTY;
                end else if (i_req.index >= r_count) begin
                    n_rsp.status = ST_BADIDX;
                end else begin
                    op      = OP_REMOVE;
                    n_count = r_count - 1'b1;
                end
            end
            MODE_FRONT, MODE_BACK: begin
                if (r_count == '0) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_rsp.data = rd_a;
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            MODE_SIZE: begin
                n_count = r_count;
            end
            MODE_GET: begin
                if (i_req.index >= r_count) begin
                    n_rsp.status = ST_BADIDX;
                end else begin
                    n_rsp.data = rd_a;
                end
            end
            MODE_REPLACE: begin
                if (i_req.index >= r_count) begin
                    n_rsp.status = ST_BADIDX;
                end else begin
                    op = OP_WRITE;
                end
            end
            MODE_EXISTS: begin
                n_rsp.flag = |match_vec;
            end
            MODE_EQUAL: begin
                if (i_req.index >= r_count) begin
                    n_rsp.status = ST_BADIDX;
                end else begin
                    n_rsp.flag = (rd_a == i_req.value);
                end
            end
            MODE_SWAP: begin
                if (i_req.index >= r_count || pos2 >= r_count) begin
                    n_rsp.status = ST_BADIDX;
                end else begin
                    op = OP_SWAP;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_rsp.count = n_count;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam t_cnt CI = CNT_W'(g);
        t_word prev_data;
        t_word next_data;

        if (g == 0) begin : g_first
            assign prev_data = '0;
        end else begin : g_mid_prev
            assign prev_data = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_data = '0;
        end else begin : g_mid_next
            assign next_data = cell_data[g+1];
        end

        always_comb begin
            cell_ctl[g].src = SRC_HOLD;
            cell_ctl[g].alt = rd_b;
            case (op_act)
                OP_INSERT: begin
                    if (CI == pos) begin
                        cell_ctl[g].src = SRC_VALUE;
                    end else if (CI > pos) begin
                        cell_ctl[g].src = SRC_PREV;
                    end
                end
                OP_REMOVE: begin
                    if (CI >= pos) begin
                        cell_ctl[g].src = SRC_NEXT;
                    end
                end
                OP_WRITE: begin
                    if (CI == pos) begin
                        cell_ctl[g].src = SRC_VALUE;
                    end
                end
                OP_SWAP: begin
                    if (CI == pos) begin
                        cell_ctl[g].src = SRC_ALT;
                    end else if (CI == pos2) begin
                        cell_ctl[g].src = SRC_ALT;
                        cell_ctl[g].alt = rd_a;
                    end
                end
                default: begin
                    cell_ctl[g].src = SRC_HOLD;
                end
            endcase
        end

        ile_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[g]),
            .i_prev  (prev_data),
            .i_next  (next_data),
            .i_value (i_req.value),
            .o_data  (cell_data[g]),
            .o_match (cell_match[g])
        );

        assign match_vec[g] = cell_match[g] && (CI < r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("list count beyond capacity");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_rsp.status == ST_FULL) |=> $stable(r_count))
        else $error("count changed on a refused push");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req.mode == MODE_CLEAR) |=> (r_count == '0))
        else $error("clear left elements");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req.mode == MODE_PUSHBACK && n_rsp.status == ST_OK)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow the list");

    a_rsp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_rsp.count == r_count))
        else $error("result count differs from list count");

endmodule

### bench/indexed_list_engine_top_test.sv
// Self-checking testbench for the indexed list engine: directed and random requests against a list model.
`timescale 1ns / 1ps

module indexed_list_engine_top_test;
    import ile_pkg::*;

    localparam int          CLK_HALF     = 4;
    localparam int          SETTLE_TAIL  = 8;
    localparam int          PRINT_LIMIT  = 40;
    localparam logic [3:0]  MODE_UNUSED  = 4'd15;
    localparam t_word       WORD_MAX     = 32'sh7fff_ffff;
    localparam t_word       WORD_MIN     = 32'sh8000_0000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_req   i_req;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_rsp  o_rsp;

    t_word     list_words [CAPACITY];
    int        list_len;
    t_out_rsp  pending_rsps [$];
    t_out_rsp  rsp_want;
    int        error_count;
    int        grow_pct;
    bit        source_steady;
    bit        sink_steady;

    indexed_list_engine_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req       (i_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_rsp       (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(2_000_000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic void insert_word(input int pos, input t_word v);
        int i;
        for (i = list_len; i > pos; i--) list_words[i] = list_words[i - 1];
        list_words[pos] = v;
        list_len++;
    endfunction

    function automatic void remove_word(input int pos);
        int i;
        for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
        list_len--;
    endfunction

    function automatic t_out_rsp predict_list_op(input t_in_req req);
        t_out_rsp rsp;
        t_word    held;
        int       n;
        int       pos;
        int       pos2;
        int       i;
        rsp  = '0;
        n    = list_len;
        pos  = req.index;
        pos2 = req.second_index;
        case (req.mode)
            MODE_PUSHBACK: begin
                if (n >= CAPACITY) rsp.status = ST_FULL;
                else insert_word(n, req.value);
            end
            MODE_PUSHFRONT: begin
                if (n >= CAPACITY) rsp.status = ST_FULL;
                else insert_word(0, req.value);
            end
            MODE_INSERT: begin
                if (pos > n) rsp.status = ST_BADIDX;
                else if (n >= CAPACITY) rsp.status = ST_FULL;
                else insert_word(pos, req.value);
            end
            MODE_POPFRONT: begin
                if (n == 0) rsp.status = ST_EMPTY;
                else remove_word(0);
            end
            MODE_POPBACK: begin
                if (n == 0) rsp.status = ST_EMPTY;
                else remove_word(n - 1);
            end
            MODE_DELETE: begin
                if (n == 0) rsp.status = ST_EMPTY;
                else if (pos >= n) rsp.status = ST_BADIDX;
                else remove_word(pos);
            end
            MODE_FRONT: begin
                if (n == 0) rsp.status = ST_EMPTY;
                else rsp.data = list_words[0];
            end
            MODE_BACK: begin
                if (n == 0) rsp.status = ST_EMPTY;
                else rsp.data = list_words[n - 1];
            end
            MODE_CLEAR: list_len = 0;
            MODE_GET: begin
                if (pos >= n) rsp.status = ST_BADIDX;
                else rsp.data = list_words[pos];
            end
            MODE_REPLACE: begin
                if (pos >= n) rsp.status = ST_BADIDX;
                else list_words[pos] = req.value;
            end
            MODE_EXISTS: begin
                for (i = 0; i < n; i++)
                    if (list_words[i] == req.value) rsp.flag = 1'b1;
            end
            MODE_EQUAL: begin
                if (pos >= n) rsp.status = ST_BADIDX;
                else rsp.flag = (list_words[pos] == req.value);
            end
            MODE_SWAP: begin
                if (pos >= n || pos2 >= n) begin
                    rsp.status = ST_BADIDX;
                end else begin
                    held             = list_words[pos];
                    list_words[pos]  = list_words[pos2];
                    list_words[pos2] = held;
                end
            end
            default: ;
        endcase
        rsp.count = t_cnt'(list_len);
        return rsp;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rsps.size() == 0) begin
                report_mismatch($sformatf("result with no request pending: %p", o_rsp));
            end else begin
                rsp_want = pending_rsps[0];
                pending_rsps.delete(0);
                if (o_rsp.data !== rsp_want.data)
                    report_mismatch($sformatf("data %0d, want %0d", o_rsp.data, rsp_want.data));
                if (o_rsp.flag !== rsp_want.flag)
                    report_mismatch($sformatf("flag %b, want %b", o_rsp.flag, rsp_want.flag));
                if (o_rsp.count !== rsp_want.count)
                    report_mismatch($sformatf("count %0d, want %0d", o_rsp.count, rsp_want.count));
                if (o_rsp.status !== rsp_want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_rsp.status,
                                              rsp_want.status));
            end
        end
    end

    initial begin
        int hold;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            hold = sink_steady ? 0 : pick_gap();
            if (hold > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (hold - 1) @(negedge i_clk);
            end
        end
    end

    task automatic send_request(input t_in_req req);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_req      <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_rsps = {pending_rsps, predict_list_op(req)};
        gap = source_steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_op(input logic [3:0] mode, input t_word value,
                           input int index, input int second);
        t_in_req req;
        req.mode         = mode;
        req.value        = value;
        req.index        = index[4:0];
        req.second_index = second[3:0];
        send_request(req);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_rsps.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_word pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (list_len > 0 && r < 40) return list_words[$urandom_range(0, list_len - 1)];
        if (r < 50) begin
            case ($urandom_range(0, 3))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return '0;
                default: return -1;
            endcase
        end
        return t_word'($urandom);
    endfunction

    function automatic int pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (list_len > 0 && r < 70) return $urandom_range(0, list_len - 1);
        if (r < 88) return $urandom_range(0, list_len);
        return $urandom_range(0, 31);
    endfunction

    function automatic t_in_req random_request();
        t_in_req req;
        int      r;
        r                = $urandom_range(0, 99);
        req.value        = pick_value();
        req.index        = 5'(pick_index());
        req.second_index = (list_len > 0 && $urandom_range(0, 99) < 80)
                           ? 4'($urandom_range(0, list_len - 1)) : 4'($urandom_range(0, 15));
        if (r < grow_pct) begin
            case ($urandom_range(0, 2))
                0: req.mode = MODE_PUSHBACK;
                1: req.mode = MODE_PUSHFRONT;
                default: req.mode = MODE_INSERT;
            endcase
        end else if (r < grow_pct + 25) begin
            case ($urandom_range(0, 2))
                0: req.mode = MODE_POPFRONT;
                1: req.mode = MODE_POPBACK;
                default: req.mode = MODE_DELETE;
            endcase
        end else begin
            case ($urandom_range(0, 49))
                0: req.mode = MODE_CLEAR;
                1: req.mode = MODE_UNUSED;
                default: begin
                    case ($urandom_range(0, 7))
                        0: req.mode = MODE_FRONT;
                        1: req.mode = MODE_BACK;
                        2: req.mode = MODE_SIZE;
                        3: req.mode = MODE_GET;
                        4: req.mode = MODE_REPLACE;
                        5: req.mode = MODE_EXISTS;
                        6: req.mode = MODE_EQUAL;
                        default: req.mode = MODE_SWAP;
                    endcase
                end
            endcase
        end
        return req;
    endfunction

    task automatic test_empty_list();
        send_op(MODE_POPFRONT, '0, 0, 0);
        send_op(MODE_POPBACK,  '0, 0, 0);
        send_op(MODE_DELETE,   '0, 31, 0);
        send_op(MODE_FRONT,    '0, 0, 0);
        send_op(MODE_BACK,     '0, 0, 0);
        send_op(MODE_GET,      '0, 0, 0);
        send_op(MODE_REPLACE,  WORD_MAX, 0, 0);
        send_op(MODE_EQUAL,    '0, 0, 0);
        send_op(MODE_SWAP,     '0, 0, 15);
        send_op(MODE_EXISTS,   '0, 0, 0);
        send_op(MODE_INSERT,   WORD_MIN, 1, 0);
        send_op(MODE_UNUSED,   -1, 31, 15);
        wait_for_results();
    endtask

    task automatic test_basic_ops();
        send_op(MODE_INSERT,    WORD_MAX, 0, 0);
        send_op(MODE_PUSHBACK,  WORD_MIN, 0, 0);
        send_op(MODE_PUSHFRONT, -1, 0, 0);
        send_op(MODE_FRONT,     '0, 0, 0);
        send_op(MODE_BACK,      '0, 0, 0);
        send_op(MODE_GET,       '0, 1, 0);
        send_op(MODE_EXISTS,    WORD_MIN, 0, 0);
        send_op(MODE_EQUAL,     -1, 0, 0);
        send_op(MODE_SWAP,      '0, 0, 2);
        send_op(MODE_REPLACE,   '0, 1, 0);
        send_op(MODE_SIZE,      '0, 0, 0);
        send_op(MODE_DELETE,    '0, 3, 0);
        send_op(MODE_DELETE,    '0, 1, 0);
        send_op(MODE_CLEAR,     '0, 0, 0);
        wait_for_results();
    endtask

    task automatic test_capacity();
        while (list_len < CAPACITY) begin
            if ($urandom_range(0, 1)) send_op(MODE_PUSHBACK, pick_value(), 0, 0);
            else send_op(MODE_INSERT, t_word'($urandom), $urandom_range(0, list_len), 0);
        end
        send_op(MODE_PUSHBACK,  WORD_MAX, 0, 0);
        send_op(MODE_PUSHFRONT, WORD_MIN, 0, 0);
        send_op(MODE_INSERT,    '0, 16, 0);
        send_op(MODE_INSERT,    '0, 17, 0);
        send_op(MODE_GET,       '0, 15, 0);
        send_op(MODE_GET,       '0, 16, 0);
        send_op(MODE_SWAP,      '0, 15, 0);
        send_op(MODE_EXISTS,    list_words[15], 0, 0);
        send_op(MODE_DELETE,    '0, 15, 0);
        send_op(MODE_INSERT,    WORD_MIN, 15, 0);
        send_op(MODE_CLEAR,     '0, 0, 0);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int phase;
        int k;
        for (phase = 0; phase < 8; phase++) begin
            grow_pct      = (phase % 2 == 0) ? 50 : 8;
            source_steady = (phase == 3);
            sink_steady   = (phase == 3 || phase == 6);
            for (k = 0; k < 50; k++) send_request(random_request());
            if (phase == 4) wait_for_results();
        end
        source_steady = 1'b0;
        sink_steady   = 1'b0;
        wait_for_results();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_req         = '0;
        list_len      = 0;
        error_count   = 0;
        grow_pct      = 40;
        source_steady = 1'b0;
        sink_steady   = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_basic_ops();
        test_capacity();
        test_random_traffic();

        wait_for_results();
        repeat (SETTLE_TAIL) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/ile_pkg.sv
rtl/core/ile_cell.sv
rtl/core/indexed_list_engine_top.sv
bench/indexed_list_engine_top_test.sv
